// ===== hw/rtl/mlptq_pkg.sv =====
package mlptq_pkg;

    localparam int OP_W = 2;
    localparam int LEVEL_W = 2;
    localparam int TAG_W = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W = 3;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 3'd3;

endpackage

// ===== hw/rtl/multi_level_priority_task_queue_unit.sv =====
// Add, out-of-range and ignored requests go from the decide state straight to the finish state.
// Take next and remove also pass through a scan state that reads the N entries of the level
// touched, N being at most QUEUE_DEPTH; an empty level is not scanned.
// A new request is accepted only after the result is loaded, so one request is handled at a
// time; the result waits in an output register until it is taken.
// Synchronous active-low reset empties every level and sets the level register to 3.
module multi_level_priority_task_queue_unit #(
    parameter int MAX_LEVELS = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_write_enable,
    input  logic [mlptq_pkg::CFG_W-1:0]      cfg_write_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mlptq_pkg::OP_W-1:0]       s_operation,
    input  logic [mlptq_pkg::LEVEL_W-1:0]    s_level,
    input  logic [mlptq_pkg::TAG_W-1:0]      s_task_tag,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mlptq_pkg::STATUS_W-1:0]   m_status,
    output logic [mlptq_pkg::TAG_W-1:0]      m_served_tag,
    output logic [mlptq_pkg::LEVEL_W-1:0]    m_served_level
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int AW = $clog2(MAX_LEVELS + 1);
    localparam int KW = (AW > mlptq_pkg::CFG_W) ? AW : mlptq_pkg::CFG_W;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int WORDS = MAX_LEVELS * QUEUE_DEPTH;
    localparam int ADW = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [TAG_BITS-1:0] entry_store [WORDS];
    logic [TAG_BITS-1:0] mem_rd_data_reg;
    logic                mem_rd_en;
    logic [ADW-1:0]      mem_rd_addr;
    logic                mem_wr_en;
    logic [ADW-1:0]      mem_wr_addr;
    logic [TAG_BITS-1:0] mem_wr_data;

    logic [CNTW-1:0] level_count_reg [MAX_LEVELS];
    logic            cnt_wr_en;
    logic [LW-1:0]   cnt_wr_lvl;
    logic [CNTW-1:0] cnt_wr_val;

    logic [mlptq_pkg::CFG_W-1:0] levels_in_use_reg;

    logic [1:0] state_reg, state_next;
    logic [mlptq_pkg::OP_W-1:0] req_op_reg;
    logic [mlptq_pkg::LEVEL_W-1:0] req_level_reg;
    logic [TAG_BITS-1:0] req_tag_reg;

    logic [CNTW-1:0] rd_pos_reg, rd_pos_next;
    logic [PW-1:0]   data_pos_reg, data_pos_next;
    logic            found_reg, found_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic [LW-1:0]   work_lvl_reg, work_lvl_next;
    logic            is_take_reg, is_take_next;
    logic [mlptq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;

    logic m_valid_reg, m_valid_next;
    logic [mlptq_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [mlptq_pkg::TAG_W-1:0] m_served_tag_reg, m_served_tag_next;
    logic [mlptq_pkg::LEVEL_W-1:0] m_served_level_reg, m_served_level_next;

    logic [KW-1:0]   act_k;
    logic [LW-1:0]   req_lvl_idx;
    logic            req_in_range;
    logic [CNTW-1:0] req_count;
    logic            take_hit;
    logic [LW-1:0]   take_lvl;
    logic [CNTW-1:0] take_count;
    logic            match;

    function automatic logic [ADW-1:0] addr_of(input logic [LW-1:0] lvl,
                                               input logic [PW-1:0] pos);
        addr_of = ADW'(ADW'(lvl) * ADW'(QUEUE_DEPTH)) + ADW'(pos);
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_served_tag = m_served_tag_reg;
    assign m_served_level = m_served_level_reg;

    always_comb begin
        act_k = (KW'(levels_in_use_reg) > KW'(MAX_LEVELS)) ? KW'(MAX_LEVELS)
                                                           : KW'(levels_in_use_reg);
        req_lvl_idx = LW'(req_level_reg);
        req_in_range = KW'(req_level_reg) < act_k;
        req_count = level_count_reg[req_lvl_idx];
        take_hit = 1'b0;
        take_lvl = '0;
        take_count = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (!take_hit && (KW'(i) < act_k) && (level_count_reg[i] != '0)) begin
                take_hit = 1'b1;
                take_lvl = LW'(i);
                take_count = level_count_reg[i];
            end
        end
        match = is_take_reg ? (data_pos_reg == '0) : (mem_rd_data_reg == req_tag_reg);
    end

    always_comb begin
        state_next = state_reg;
        rd_pos_next = rd_pos_reg;
        data_pos_next = data_pos_reg;
        found_next = found_reg;
        n_next = n_reg;
        work_lvl_next = work_lvl_reg;
        is_take_next = is_take_reg;
        res_status_next = res_status_reg;
        res_tag_next = res_tag_reg;
        mem_rd_en = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = req_tag_reg;
        cnt_wr_en = 1'b0;
        cnt_wr_lvl = work_lvl_reg;
        cnt_wr_val = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_served_tag_next = m_served_tag_reg;
        m_served_level_next = m_served_level_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_tag_next = '0;
                work_lvl_next = '0;
                found_next = 1'b0;
                rd_pos_next = CNTW'(1);
                data_pos_next = '0;
                is_take_next = 1'b0;
                state_next = S_FINISH;
                unique case (req_op_reg)
                    mlptq_pkg::OP_ADD: begin
                        if (!req_in_range) begin
                            res_status_next = mlptq_pkg::ST_BAD_LEVEL;
                        end else if (req_count >= CNTW'(QUEUE_DEPTH)) begin
                            res_status_next = mlptq_pkg::ST_FULL;
                        end else begin
                            res_status_next = mlptq_pkg::ST_DONE;
                            mem_wr_en = 1'b1;
                            mem_wr_addr = addr_of(req_lvl_idx, PW'(req_count));
                            cnt_wr_en = 1'b1;
                            cnt_wr_lvl = req_lvl_idx;
                            cnt_wr_val = req_count + CNTW'(1);
                        end
                    end
                    mlptq_pkg::OP_TAKE: begin
                        res_status_next = mlptq_pkg::ST_NOT_FOUND;
                        if (take_hit) begin
                            is_take_next = 1'b1;
                            work_lvl_next = take_lvl;
                            n_next = take_count;
                            mem_rd_en = 1'b1;
                            mem_rd_addr = addr_of(take_lvl, '0);
                            state_next = S_SCAN;
                        end
                    end
                    mlptq_pkg::OP_REMOVE: begin
                        if (!req_in_range) begin
                            res_status_next = mlptq_pkg::ST_BAD_LEVEL;
                        end else begin
                            res_status_next = mlptq_pkg::ST_NOT_FOUND;
                            if (req_count != '0) begin
                                work_lvl_next = req_lvl_idx;
                                n_next = req_count;
                                mem_rd_en = 1'b1;
                                mem_rd_addr = addr_of(req_lvl_idx, '0);
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        res_status_next = mlptq_pkg::ST_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (rd_pos_reg < n_reg) begin
                    mem_rd_en = 1'b1;
                    mem_rd_addr = addr_of(work_lvl_reg, PW'(rd_pos_reg));
                    rd_pos_next = rd_pos_reg + CNTW'(1);
                end
                data_pos_next = data_pos_reg + PW'(1);
                found_next = found_reg || match;
                if (is_take_reg && (data_pos_reg == '0)) begin
                    res_tag_next = mem_rd_data_reg;
                end
                // Once the entry is found, every later word moves up one place.
                if (found_reg) begin
                    mem_wr_en = 1'b1;
                    mem_wr_addr = addr_of(work_lvl_reg, data_pos_reg - PW'(1));
                    mem_wr_data = mem_rd_data_reg;
                end
                if (data_pos_reg == PW'(n_reg - CNTW'(1))) begin
                    state_next = S_FINISH;
                    if (found_next) begin
                        res_status_next = mlptq_pkg::ST_DONE;
                        cnt_wr_en = 1'b1;
                        cnt_wr_lvl = work_lvl_reg;
                        cnt_wr_val = n_reg - CNTW'(1);
                    end else begin
                        res_status_next = mlptq_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_served_tag_next = mlptq_pkg::TAG_W'(res_tag_reg);
                    m_served_level_next = is_take_reg ? mlptq_pkg::LEVEL_W'(work_lvl_reg)
                                                      : '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            entry_store[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            mem_rd_data_reg <= entry_store[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            levels_in_use_reg <= mlptq_pkg::LEVELS_RESET;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                level_count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write_enable) begin
                levels_in_use_reg <= cfg_write_data;
            end
            if (cnt_wr_en) begin
                level_count_reg[cnt_wr_lvl] <= cnt_wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_op_reg <= s_operation;
            req_level_reg <= s_level;
            req_tag_reg <= TAG_BITS'(s_task_tag);
        end
        rd_pos_reg <= rd_pos_next;
        data_pos_reg <= data_pos_next;
        found_reg <= found_next;
        n_reg <= n_next;
        work_lvl_reg <= work_lvl_next;
        is_take_reg <= is_take_next;
        res_status_reg <= res_status_next;
        res_tag_reg <= res_tag_next;
        m_status_reg <= m_status_next;
        m_served_tag_reg <= m_served_tag_next;
        m_served_level_reg <= m_served_level_next;
    end

endmodule
